// File: rtl/core/three_level_page_table_mapper_macros.svh
// assertion macros for the page table mapper checker
`ifndef THREE_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH
`define THREE_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH

// same-cycle implication, masked during reset
`define PTM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page table mapper check failed");

// next-cycle implication, masked during reset
`define PTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page table mapper check failed");

`endif

// File: rtl/core/ptm_pkg.sv
// shared types, constants and entry helpers for the page table mapper
`default_nettype none

package ptm_pkg;

  // store geometry
  localparam int TABLE_PAGES      = 8;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int STORE_WORDS      = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int WIDX_W           = $clog2(STORE_WORDS);
  localparam int IDX_W            = $clog2(ENTRIES_PER_PAGE);
  localparam logic [63:0] WINDOW_BYTES = 64'(STORE_WORDS) << 3;

  // entry flag positions
  localparam int BIT_V = 0;
  localparam int BIT_R = 1;
  localparam int BIT_W = 2;
  localparam int BIT_X = 3;
  localparam int BIT_G = 5;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_MAP    = 2'd1,
    MODE_READ   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALIGN   = 2'd1,
    ST_NOSPARE = 2'd2,
    ST_WINDOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ASEL_SPARE,
    ASEL_ROOT,
    ASEL_MID,
    ASEL_LEAF,
    ASEL_WORD
  } addr_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_ZERO,
    WR_LINK,
    WR_LEAF
  } wr_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_RD_CHK,
    S_RD_WAIT,
    S_WALK_CHK,
    S_WALK_RD,
    S_WALK_NEXT,
    S_LEAF_CHK,
    S_SPARE,
    S_SPARE_CHK,
    S_ZERO,
    S_LINK,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      addr_load;
    addr_sel_t addr_sel;
    logic      rd_en;
    wr_sel_t   wr_sel;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      entry_capture;
    logic      next_from_entry;
    logic      next_from_addr;
    logic      used_inc;
    logic      result_from_addr;
    logic      result_from_rdata;
    logic      status_load;
    status_t   status_code;
    logic      out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  win_ok;
    logic  entry_valid;
    logic  spare_none;
    logic  spare_misaligned;
    logic  map_misaligned;
    logic  read_misaligned;
    logic  zero_last;
    logic  clear_last;
  } stat_t;

  // next-level link entry for a table page
  function automatic logic [63:0] link_entry(input logic [55:0] page);
    logic [9:0] flags;
    flags        = '0;
    flags[BIT_V] = 1'b1;
    return {10'b0, page[55:12], flags};
  endfunction

  // leaf entry for a mapped page
  function automatic logic [63:0] leaf_entry(input logic [55:0] pa, input logic r,
                                             input logic w, input logic x,
                                             input logic g);
    logic [9:0] flags;
    flags        = '0;
    flags[BIT_V] = 1'b1;
    flags[BIT_R] = r;
    flags[BIT_W] = w;
    flags[BIT_X] = x;
    flags[BIT_G] = g;
    return {10'b0, pa[55:12], flags};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/three_level_page_table_mapper.sv
// top level of the three-level page table mapper
//
//  channel  signals                          direction  accepted when
//  cfg      cfg_write_en, cfg_write_data     in         cfg_write_en
//  in       in_valid, in_stall, mode...      in         in_valid && !in_stall
//  out      out_valid, out_stall, status...  out        out_valid && !out_stall
//
// after reset the table store is cleared one word a cycle, all 4096 words, in_stall high
// create and map wait on zeroing each new page through the single store write port
// one request is worked at a time; a new one is taken while the last result waits
// a result waiting under out_stall holds the sequencer at its last step
`default_nettype none

module three_level_page_table_mapper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [55:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [55:0] root_addr,
  input  wire logic [38:0] vaddr,
  input  wire logic [55:0] paddr,
  input  wire logic        can_read,
  input  wire logic        can_write,
  input  wire logic        can_execute,
  input  wire logic        is_global,
  input  wire logic [55:0] spare_page_a,
  input  wire logic [55:0] spare_page_b,
  input  wire logic [1:0]  spares_available,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [63:0]      result_word,
  output logic [1:0]       pages_used
);
  import ptm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  ptm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath and table store
  ptm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .mode             (mode),
    .root_addr        (root_addr),
    .vaddr            (vaddr),
    .paddr            (paddr),
    .can_read         (can_read),
    .can_write        (can_write),
    .can_execute      (can_execute),
    .is_global        (is_global),
    .spare_page_a     (spare_page_a),
    .spare_page_b     (spare_page_b),
    .spares_available (spares_available),
    .cmd              (cmd),
    .stat             (stat),
    .status           (status),
    .result_word      (result_word),
    .pages_used       (pages_used)
  );

endmodule

`default_nettype wire

// File: rtl/core/ptm_ctrl.sv
// sequencer for reset clearing, create, map walk, page zeroing and read
`default_nettype none

module ptm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ptm_pkg::cmd_t      cmd,
  input  wire ptm_pkg::stat_t stat
);
  import ptm_pkg::*;

  state_t state, state_next;
  logic   top_level, top_level_next;

  // state and level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      top_level <= 1'b0;
    end else begin
      state     <= state_next;
      top_level <= top_level_next;
    end
  end

  // output valid: set on load, dropped when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    top_level_next = top_level;
    cmd            = '0;
    in_stall       = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.wr_sel  = WR_CLEAR;
        cmd.cnt_inc = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (stat.mode)
          MODE_CREATE: state_next = S_SPARE;
          MODE_MAP: begin
            if (stat.map_misaligned) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_ALIGN;
              state_next      = S_FINISH;
            end else begin
              cmd.addr_load  = 1'b1;
              cmd.addr_sel   = ASEL_ROOT;
              top_level_next = 1'b1;
              state_next     = S_WALK_CHK;
            end
          end
          MODE_READ: begin
            if (stat.read_misaligned) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_ALIGN;
              state_next      = S_FINISH;
            end else begin
              cmd.addr_load = 1'b1;
              cmd.addr_sel  = ASEL_WORD;
              state_next    = S_RD_CHK;
            end
          end
          MODE_UNUSED: state_next = S_FINISH;
        endcase
      end
      S_RD_CHK: begin
        if (!stat.win_ok) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_WINDOW;
          state_next      = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        cmd.result_from_rdata = 1'b1;
        state_next            = S_FINISH;
      end
      S_WALK_CHK: begin
        if (!stat.win_ok) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_WINDOW;
          state_next      = S_FINISH;
        end else begin
          cmd.rd_en         = 1'b1;
          cmd.entry_capture = 1'b1;
          state_next        = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (stat.entry_valid) begin
          cmd.next_from_entry = 1'b1;
          state_next          = S_WALK_NEXT;
        end else begin
          state_next = S_SPARE;
        end
      end
      S_WALK_NEXT: begin
        cmd.addr_load = 1'b1;
        if (top_level) begin
          cmd.addr_sel   = ASEL_MID;
          top_level_next = 1'b0;
          state_next     = S_WALK_CHK;
        end else begin
          cmd.addr_sel = ASEL_LEAF;
          state_next   = S_LEAF_CHK;
        end
      end
      S_LEAF_CHK: begin
        if (!stat.win_ok) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_WINDOW;
        end else begin
          cmd.wr_sel = WR_LEAF;
        end
        state_next = S_FINISH;
      end
      S_SPARE: begin
        if (stat.spare_none) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_NOSPARE;
          state_next      = S_FINISH;
        end else if (stat.spare_misaligned) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_ALIGN;
          state_next      = S_FINISH;
        end else begin
          cmd.addr_load = 1'b1;
          cmd.addr_sel  = ASEL_SPARE;
          state_next    = S_SPARE_CHK;
        end
      end
      S_SPARE_CHK: begin
        if (!stat.win_ok) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_WINDOW;
          state_next      = S_FINISH;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.wr_sel  = WR_ZERO;
        cmd.cnt_inc = 1'b1;
        if (stat.zero_last) begin
          cmd.used_inc = 1'b1;
          if (stat.mode == MODE_CREATE) begin
            cmd.result_from_addr = 1'b1;
            state_next           = S_FINISH;
          end else begin
            state_next = S_LINK;
          end
        end
      end
      S_LINK: begin
        cmd.wr_sel         = WR_LINK;
        cmd.next_from_addr = 1'b1;
        state_next         = S_WALK_NEXT;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ptm_dp.sv
// datapath: request registers, window check, table store and result registers
`default_nettype none

module ptm_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write_en,
  input  wire logic [55:0]   cfg_write_data,
  input  wire logic [1:0]    mode,
  input  wire logic [55:0]   root_addr,
  input  wire logic [38:0]   vaddr,
  input  wire logic [55:0]   paddr,
  input  wire logic          can_read,
  input  wire logic          can_write,
  input  wire logic          can_execute,
  input  wire logic          is_global,
  input  wire logic [55:0]   spare_page_a,
  input  wire logic [55:0]   spare_page_b,
  input  wire logic [1:0]    spares_available,
  input  wire ptm_pkg::cmd_t cmd,
  output ptm_pkg::stat_t     stat,
  output logic [1:0]         status,
  output logic [63:0]        result_word,
  output logic [1:0]         pages_used
);
  import ptm_pkg::*;

  localparam logic [WIDX_W-1:0] OFS_MASK = WIDX_W'(ENTRIES_PER_PAGE - 1);
  localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(STORE_WORDS - 1);

  // window base, page bits only
  logic [43:0] win_base;

  // request registers
  mode_t       mode_r;
  logic [55:0] root_r;
  logic [38:0] va_r;
  logic [55:0] pa_r;
  logic        r_r, w_r, x_r, g_r;
  logic [55:0] spare_a_r, spare_b_r;
  logic [1:0]  avail_r;

  // walk state
  logic [63:0]       addr_r, addr_next;
  logic [63:0]       next_r;
  logic [WIDX_W-1:0] entry_idx;
  logic [WIDX_W-1:0] cnt;
  logic [1:0]        used_r;
  logic [63:0]       result_r;
  status_t           status_r;

  // store
  logic [63:0]       store [STORE_WORDS];
  logic [63:0]       rdata;
  logic              we;
  logic [WIDX_W-1:0] waddr;
  logic [63:0]       wdata;

  // window lookup
  logic [64:0]       diff;
  logic              win_ok;
  logic [WIDX_W-1:0] widx;
  logic [55:0]       spare_sel;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      win_base <= '0;
    end else if (cfg_write_en) begin
      win_base <= cfg_write_data[55:12];
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode_t'(mode);
      root_r    <= root_addr;
      va_r      <= vaddr;
      pa_r      <= paddr;
      r_r       <= can_read;
      w_r       <= can_write;
      x_r       <= can_execute;
      g_r       <= is_global;
      spare_a_r <= spare_page_a;
      spare_b_r <= spare_page_b;
      avail_r   <= (spares_available == 2'd3) ? 2'd2 : spares_available;
    end
  end

  // address source selection
  assign spare_sel = (used_r == 2'd0) ? spare_a_r : spare_b_r;

  always_comb begin
    unique case (cmd.addr_sel)
      ASEL_SPARE: addr_next = {8'b0, spare_sel};
      ASEL_ROOT:  addr_next = {8'b0, root_r[55:12], va_r[38:30], 3'b0};
      ASEL_MID:   addr_next = {next_r[63:12], va_r[29:21], 3'b0};
      ASEL_LEAF:  addr_next = {next_r[63:12], va_r[20:12], 3'b0};
      ASEL_WORD:  addr_next = {8'b0, pa_r};
      default:    addr_next = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_load) addr_r <= addr_next;
  end

  // window check and word index
  assign diff   = {1'b0, addr_r} - {9'b0, win_base, 12'b0};
  assign win_ok = !diff[64] && (diff[63:0] < WINDOW_BYTES);
  assign widx   = diff[WIDX_W+2:3];

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.entry_capture) entry_idx <= widx;
    if (cmd.next_from_entry) begin
      next_r <= {rdata[61:10], 12'b0};
    end else if (cmd.next_from_addr) begin
      next_r <= addr_r;
    end
  end

  // sweep counter for reset clearing and page zeroing
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // per-request result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      used_r   <= 2'd0;
      result_r <= '0;
      status_r <= ST_OK;
    end else begin
      if (cmd.used_inc)          used_r   <= used_r + 2'd1;
      if (cmd.result_from_addr)  result_r <= addr_r;
      if (cmd.result_from_rdata) result_r <= rdata;
      if (cmd.status_load)       status_r <= cmd.status_code;
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= status_r;
      result_word <= result_r;
      pages_used  <= used_r;
    end
  end

  // store write port
  always_comb begin
    we    = 1'b1;
    waddr = widx;
    wdata = '0;
    unique case (cmd.wr_sel)
      WR_NONE:  we = 1'b0;
      WR_CLEAR: waddr = cnt;
      WR_ZERO:  waddr = (widx & ~OFS_MASK) | (cnt & OFS_MASK);
      WR_LINK: begin
        waddr = entry_idx;
        wdata = link_entry(addr_r[55:0]);
      end
      WR_LEAF:  wdata = leaf_entry(pa_r, r_r, w_r, x_r, g_r);
      default:  we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= store[widx];
  end

  // status to controller
  assign stat.mode             = mode_r;
  assign stat.win_ok           = win_ok;
  assign stat.entry_valid      = rdata[BIT_V];
  assign stat.spare_none       = (used_r >= avail_r);
  assign stat.spare_misaligned = |spare_sel[11:0];
  assign stat.map_misaligned   = |root_r[11:0] || |va_r[11:0] || |pa_r[11:0];
  assign stat.read_misaligned  = |pa_r[2:0];
  assign stat.zero_last        = ((cnt & OFS_MASK) == OFS_MASK);
  assign stat.clear_last       = (cnt == LAST_IDX);

endmodule

`default_nettype wire

// File: rtl/core/ptm_checker.sv
// port-level checks for the page table mapper, bound to the top level
`default_nettype none

`include "three_level_page_table_mapper_macros.svh"

module ptm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [63:0] result_word,
  input wire logic [1:0]  pages_used
);
  import ptm_pkg::*;

  // stalled result transaction holds its payload
  `PTM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(result_word) && $stable(pages_used))

  // failed requests carry a zero result word
  `PTM_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && (status != ST_OK), result_word == 64'd0)

  // an accepted request keeps the input stalled while it is worked
  `PTM_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // at most two spare pages are consumed
  `PTM_ASSERT_NOW(a_pages_bound, clk, rst, out_valid, pages_used != 2'd3)

endmodule

bind three_level_page_table_mapper ptm_checker u_ptm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .result_word (result_word),
  .pages_used  (pages_used)
);

`default_nettype wire

// File: sim/tb_ptm_scoreboard_pkg.sv
// request and reply types plus the table walk scoreboard for the page table mapper testbench
package tb_ptm_scoreboard_pkg;
  import ptm_pkg::*;

  // one request transaction as driven on the input channel
  typedef struct {
    mode_t       mode;
    logic [55:0] root;
    logic [38:0] va;
    logic [55:0] pa;
    logic        rd;
    logic        wr;
    logic        ex;
    logic        gl;
    logic [55:0] spare_a;
    logic [55:0] spare_b;
    logic [1:0]  avail;
  } map_request_t;

  // one reply transaction as seen on the output channel
  typedef struct {
    status_t     status;
    logic [63:0] word;
    logic [1:0]  used;
  } map_reply_t;

  class table_walk_scoreboard;
    logic [63:0] shadow_store [STORE_WORDS];
    logic [55:0] window_base;
    map_reply_t  expected_replies [$];
    int unsigned hot_words [$];
    int          errors;

    function new();
      foreach (shadow_store[i]) shadow_store[i] = '0;
      window_base = '0;
      errors = 0;
    endfunction

    function void set_window(logic [55:0] v);
      window_base = v;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // remember recently written words so reads can hit them
    function void note_hot(int unsigned w);
      hot_words.push_back(w);
      if (hot_words.size() > 64) void'(hot_words.pop_front());
    endfunction

    // byte address of a recently written word in the current window
    function logic [55:0] hot_addr();
      logic [55:0] page;
      int unsigned idx;
      page = {window_base[55:12], 12'h0};
      if (hot_words.size() == 0) return page;
      idx = hot_words[$urandom_range(hot_words.size() - 1)];
      return page + 56'(idx * 8);
    endfunction

    // byte address to store word index, 0 when outside the window
    function bit find_word(logic [63:0] addr, output int unsigned idx);
      logic [63:0] base;
      logic [63:0] off;
      idx = 0;
      base = {8'h0, window_base[55:12], 12'h0};
      if (addr < base) return 0;
      off = addr - base;
      if (off >= WINDOW_BYTES) return 0;
      idx = int'(off >> 3);
      return 1;
    endfunction

    // consume and zero the next offered spare page
    function status_t grab_spare(map_request_t r, int unsigned avail,
                                 inout int unsigned used, output logic [63:0] page);
      logic [55:0] p;
      int unsigned w;
      page = '0;
      if (used >= avail || used >= 2) return ST_NOSPARE;
      p = (used == 0) ? r.spare_a : r.spare_b;
      if (p[11:0] != 12'h0) return ST_ALIGN;
      if (!find_word({8'h0, p}, w)) return ST_WINDOW;
      if (w + ENTRIES_PER_PAGE > STORE_WORDS) return ST_WINDOW;
      for (int i = 0; i < ENTRIES_PER_PAGE; i++) shadow_store[w + i] = '0;
      used++;
      page = {8'h0, p};
      return ST_OK;
    endfunction

    // follow the entry at index of a table, linking a new page if it is empty
    function status_t step_down(logic [63:0] tbl, logic [8:0] index, map_request_t r,
                                int unsigned avail, inout int unsigned used,
                                output logic [63:0] nxt);
      int unsigned w;
      logic [63:0] entry;
      logic [63:0] page;
      status_t st;
      nxt = '0;
      if (!find_word(tbl + {52'h0, index, 3'b000}, w)) return ST_WINDOW;
      entry = shadow_store[w];
      if (entry[BIT_V]) begin
        nxt = (entry >> 10) << 12;
        return ST_OK;
      end
      st = grab_spare(r, avail, used, page);
      if (st != ST_OK) return st;
      shadow_store[w] = ((page >> 12) << 10) | 64'h1;
      note_hot(w);
      nxt = page;
      return ST_OK;
    endfunction

    // reply that a request produces, updating the shadow store
    function map_reply_t serve(map_request_t r);
      map_reply_t rep;
      int unsigned avail;
      int unsigned used;
      int unsigned w;
      logic [63:0] l1;
      logic [63:0] l0;
      logic [63:0] leaf;
      logic [63:0] page;
      logic [63:0] word;
      status_t st;
      avail = r.avail;
      if (avail > 2) avail = 2;
      used = 0;
      st = ST_OK;
      word = '0;
      case (r.mode)
        MODE_CREATE: begin
          st = grab_spare(r, avail, used, page);
          if (st == ST_OK) word = page;
        end
        MODE_MAP: begin
          if ((r.root[11:0] | r.va[11:0] | r.pa[11:0]) != 12'h0) begin
            st = ST_ALIGN;
          end else begin
            st = step_down({8'h0, r.root}, r.va[38:30], r, avail, used, l1);
            if (st == ST_OK) st = step_down(l1, r.va[29:21], r, avail, used, l0);
            if (st == ST_OK) begin
              if (!find_word(l0 + {52'h0, r.va[20:12], 3'b000}, w)) begin
                st = ST_WINDOW;
              end else begin
                leaf = (({8'h0, r.pa}) >> 12) << 10;
                leaf[BIT_V] = 1'b1;
                leaf[BIT_R] = r.rd;
                leaf[BIT_W] = r.wr;
                leaf[BIT_X] = r.ex;
                leaf[BIT_G] = r.gl;
                shadow_store[w] = leaf;
                note_hot(w);
              end
            end
          end
        end
        MODE_READ: begin
          if (r.pa[2:0] != 3'b000) st = ST_ALIGN;
          else if (!find_word({8'h0, r.pa}, w)) st = ST_WINDOW;
          else word = shadow_store[w];
        end
        default: ;
      endcase
      rep.status = st;
      rep.word = word;
      rep.used = used[1:0];
      return rep;
    endfunction

    function void note_request(map_request_t r);
      expected_replies.push_back(serve(r));
    endfunction

    // compare one accepted reply with the oldest outstanding one
    function void check_reply(logic [1:0] st, logic [63:0] word, logic [1:0] used);
      map_reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding");
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (word !== want.word) begin
        $error("result_word: expected %h, actual %h", want.word, word);
        errors++;
      end
      if (used !== want.used) begin
        $error("pages_used: expected %0d, actual %0d", want.used, used);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: sim/tb_three_level_page_table_mapper.sv
// top of the page table mapper testbench: clock, reset, stimulus, reply monitor
module tb_three_level_page_table_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import ptm_pkg::*;
  import tb_ptm_scoreboard_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [55:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = '0;
  logic [55:0] root_addr = '0;
  logic [38:0] vaddr = '0;
  logic [55:0] paddr = '0;
  logic        can_read = 1'b0;
  logic        can_write = 1'b0;
  logic        can_execute = 1'b0;
  logic        is_global = 1'b0;
  logic [55:0] spare_page_a = '0;
  logic [55:0] spare_page_b = '0;
  logic [1:0]  spares_available = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [63:0] result_word;
  logic [1:0]  pages_used;

  table_walk_scoreboard walk_board;
  logic [55:0] window_now = '0;
  bit          quiet = 1'b0;

  three_level_page_table_mapper u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .root_addr        (root_addr),
    .vaddr            (vaddr),
    .paddr            (paddr),
    .can_read         (can_read),
    .can_write        (can_write),
    .can_execute      (can_execute),
    .is_global        (is_global),
    .spare_page_a     (spare_page_a),
    .spare_page_b     (spare_page_b),
    .spares_available (spares_available),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .result_word      (result_word),
    .pages_used       (pages_used)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(20, 4);
    return $urandom_range(200, 50);
  endfunction

  function automatic logic [55:0] rand56();
    return 56'({$urandom(), $urandom()});
  endfunction

  // page address, mostly inside the current window
  function automatic logic [55:0] pick_page();
    int unsigned p;
    logic [55:0] base;
    p = $urandom_range(99);
    base = {window_now[55:12], 12'h0};
    if (p < 80) return base + 56'($urandom_range(7) * 4096);
    if (p < 88) return base + 56'($urandom_range(12, 8) * 4096);
    if (p < 94) return rand56() & 56'hFF_FFFF_FFFF_F000;
    return rand56();
  endfunction

  // level index biased to a few values so walks share tables
  function automatic logic [8:0] pick_index();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) return 9'd0;
    if (p < 45) return 9'd511;
    if (p < 60) return 9'd1;
    return 9'($urandom_range(511));
  endfunction

  function automatic logic [1:0] pick_avail();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return 2'd0;
    if (p < 25) return 2'd1;
    if (p < 85) return 2'd2;
    return 2'd3;
  endfunction

  function automatic map_request_t random_request();
    map_request_t r;
    r.mode    = mode_t'($urandom_range(3));
    r.root    = rand56();
    r.va      = 39'({$urandom(), $urandom()});
    r.pa      = rand56();
    r.rd      = 1'($urandom_range(1));
    r.wr      = 1'($urandom_range(1));
    r.ex      = 1'($urandom_range(1));
    r.gl      = 1'($urandom_range(1));
    r.spare_a = rand56();
    r.spare_b = rand56();
    r.avail   = 2'($urandom_range(3));
    return r;
  endfunction

  // mostly well-formed creates, maps and reads, the rest noise
  function automatic map_request_t shaped_request();
    map_request_t r;
    int unsigned p;
    int unsigned q;
    r = random_request();
    p = $urandom_range(99);
    q = $urandom_range(99);
    if (p < 45) begin
      r.mode    = MODE_MAP;
      r.root    = pick_page();
      r.va      = {pick_index(), pick_index(), pick_index(), 12'h0};
      if (q < 5) r.va[11:0] = 12'($urandom_range(4095, 1));
      r.pa      = {r.pa[55:12], 12'h0};
      if (q >= 95) r.pa[11:0] = 12'($urandom_range(4095, 1));
      r.spare_a = pick_page();
      r.spare_b = pick_page();
      r.avail   = pick_avail();
    end else if (p < 60) begin
      r.mode    = MODE_CREATE;
      r.spare_a = pick_page();
      r.avail   = pick_avail();
    end else if (p < 85) begin
      r.mode = MODE_READ;
      if (q < 50) r.pa = walk_board.hot_addr();
      else if (q < 85) r.pa = {window_now[55:12], 12'h0} + 56'($urandom_range(4095) * 8);
      else if (q < 93) r.pa = {window_now[55:12], 12'h0} + 56'($urandom_range(7, 1));
    end
    return r;
  endfunction

  function automatic map_request_t make_req(mode_t m, logic [55:0] root, logic [38:0] va,
                                            logic [55:0] pa, logic [3:0] perms,
                                            logic [55:0] sp_a, logic [55:0] sp_b,
                                            logic [1:0] avail);
    map_request_t r;
    r.mode    = m;
    r.root    = root;
    r.va      = va;
    r.pa      = pa;
    r.rd      = perms[0];
    r.wr      = perms[1];
    r.ex      = perms[2];
    r.gl      = perms[3];
    r.spare_a = sp_a;
    r.spare_b = sp_b;
    r.avail   = avail;
    return r;
  endfunction

  // drive one request and hold it until the transaction is accepted
  task automatic send_request(input map_request_t r);
    int unsigned gap;
    mode             <= r.mode;
    root_addr        <= r.root;
    vaddr            <= r.va;
    paddr            <= r.pa;
    can_read         <= r.rd;
    can_write        <= r.wr;
    can_execute      <= r.ex;
    is_global        <= r.gl;
    spare_page_a     <= r.spare_a;
    spare_page_b     <= r.spare_b;
    spares_available <= r.avail;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    walk_board.note_request(r);
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every reply is back
  task automatic settle();
    in_valid <= 1'b0;
    while (walk_board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [55:0] v);
    cfg_write_data <= v;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    walk_board.set_window(v);
    window_now = v;
  endtask

  // receiver back-pressure
  initial begin
    int unsigned len;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(99) < 30) begin
        len = pick_gap();
        if (len != 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      walk_board.check_reply(status, result_word, pages_used);
    end
  end

  // main sequence
  initial begin
    logic [55:0] phase_windows [6];
    map_request_t r;
    walk_board = new();
    phase_windows[0] = 56'h0;
    phase_windows[1] = 56'h00_0000_1234_5ABC;
    phase_windows[2] = 56'hFF_FFFF_FFFF_FFFF;
    phase_windows[3] = rand56();
    phase_windows[4] = 56'h80_0000_0000_0000;
    phase_windows[5] = 56'h0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: fresh store, basic build, alignment, window and spare corner cases
    send_request(make_req(MODE_READ, 56'h0, 39'h0, 56'h0, 4'h0, 56'h0, 56'h0, 2'd0));
    send_request(make_req(MODE_CREATE, 56'h0, 39'h0, 56'h0, 4'h0, 56'h0, 56'h0, 2'd1));
    send_request(make_req(MODE_MAP, 56'h0, 39'h0, 56'h5000, 4'hF,
                          56'h1000, 56'h2000, 2'd2));
    send_request(make_req(MODE_MAP, 56'h0, 39'h1000, 56'hFF_FFFF_FFFF_F000, 4'h0,
                          56'h3000, 56'h4000, 2'd2));
    send_request(make_req(MODE_READ, 56'h0, 39'h0, 56'h0, 4'h0, 56'h0, 56'h0, 2'd0));
    send_request(make_req(MODE_READ, 56'h0, 39'h0, 56'h2008, 4'h0, 56'h0, 56'h0, 2'd0));
    // misaligned root, virtual and physical address
    send_request(make_req(MODE_MAP, 56'h8, 39'h0, 56'h0, 4'h1, 56'h1000, 56'h2000, 2'd2));
    send_request(make_req(MODE_MAP, 56'h0, 39'h1, 56'h0, 4'h1, 56'h1000, 56'h2000, 2'd2));
    send_request(make_req(MODE_MAP, 56'h0, 39'h0, 56'h800, 4'h1, 56'h1000, 56'h2000, 2'd2));
    // read misaligned, just past the window, top of the address space
    send_request(make_req(MODE_READ, 56'h0, 39'h0, 56'h4, 4'h0, 56'h0, 56'h0, 2'd0));
    send_request(make_req(MODE_READ, 56'h0, 39'h0, 56'h8000, 4'h0, 56'h0, 56'h0, 2'd0));
    send_request(make_req(MODE_READ, 56'h0, 39'h0, 56'hFF_FFFF_FFFF_FFF8, 4'h0,
                          56'h0, 56'h0, 2'd0));
    // top index on every level: no spares, partial build, then completion
    send_request(make_req(MODE_MAP, 56'h0, 39'h7F_FFFF_F000, 56'h6000, 4'h3,
                          56'h3000, 56'h4000, 2'd0));
    send_request(make_req(MODE_MAP, 56'h0, 39'h7F_FFFF_F000, 56'h6000, 4'h3,
                          56'h3000, 56'h4000, 2'd1));
    send_request(make_req(MODE_MAP, 56'h0, 39'h7F_FFFF_F000, 56'h6000, 4'h5,
                          56'h4000, 56'h5000, 2'd3));
    // create with misaligned spare, spare outside the window, no spare
    send_request(make_req(MODE_CREATE, 56'h0, 39'h0, 56'h0, 4'h0, 56'h4010, 56'h0, 2'd1));
    send_request(make_req(MODE_CREATE, 56'h0, 39'h0, 56'h0, 4'h0, 56'h9000, 56'h0, 2'd1));
    send_request(make_req(MODE_CREATE, 56'h0, 39'h0, 56'h0, 4'h0, 56'h1000, 56'h0, 2'd0));
    // spare equal to root, then misaligned second spare
    send_request(make_req(MODE_MAP, 56'h6000, 39'h40_4030_00, 56'h1000, 4'h8,
                          56'h6000, 56'h6001, 2'd2));
    send_request(make_req(MODE_MAP, 56'h10000, 39'h0, 56'h0, 4'h1, 56'h1000, 56'h2000, 2'd2));
    // unused mode
    r = random_request();
    r.mode = MODE_UNUSED;
    send_request(r);
    // both spares the same page as the root
    send_request(make_req(MODE_MAP, 56'h7000, 39'h40_4030_00, 56'hABC000, 4'hA,
                          56'h7000, 56'h7000, 2'd2));
    send_request(make_req(MODE_READ, 56'h0, 39'h0, 56'h7018, 4'h0, 56'h0, 56'h0, 2'd0));

    // random phases, one window setting each
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_window(phase_windows[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 88; n++) begin
        if (n == 44) settle();
        send_request(shaped_request());
      end
    end

    // drain
    in_valid <= 1'b0;
    while (walk_board.pending() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (walk_board.errors == 0 && walk_board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
